// File: sv/ucl_pkg.sv
// Shared types, keyword table and constants of the UART command line parser.
package ucl_pkg;

	// Default line buffer size in bytes, one byte of it kept for the terminator.
	localparam int LINE_BYTES_DEF = 64;

	localparam int KEY_COUNT   = 7;
	localparam int KEY_MAX_LEN = 12;

	localparam logic [7:0] CHR_NUL   = 8'h00;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_COMMA = 8'h2C;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNKNOWN  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// Command codes, in the order the keyword prefixes are tested.
	typedef enum logic [2:0] {
		CMD_PUMP_START = 3'd0,
		CMD_PUMP_STOP  = 3'd1,
		CMD_MIST_START = 3'd2,
		CMD_MIST_STOP  = 3'd3,
		CMD_AUTO_ON    = 3'd4,
		CMD_AUTO_OFF   = 3'd5,
		CMD_CLOCK_SET  = 3'd6
	} cmd_t;

	// Phases of the time setting parse: literal prefix, then three fields each with a
	// leading-blank phase, a just-seen-sign phase and a digit phase.
	typedef enum logic [3:0] {
		PH_LITERAL   = 4'd0,
		PH_F0_START  = 4'd1,
		PH_F0_SIGN   = 4'd2,
		PH_F0_DIGITS = 4'd3,
		PH_F1_START  = 4'd4,
		PH_F1_SIGN   = 4'd5,
		PH_F1_DIGITS = 4'd6,
		PH_F2_START  = 4'd7,
		PH_F2_SIGN   = 4'd8,
		PH_F2_DIGITS = 4'd9,
		PH_DONE      = 4'd10,
		PH_FAIL      = 4'd15
	} phase_t;

	// Parser state carried from byte to byte.
	typedef struct packed {
		phase_t          phase;
		logic [2:0][7:0] field;
		logic            negative;
	} time_st_t;

	localparam time_st_t TIME_CLEAR = '{phase: PH_LITERAL, field: '0, negative: 1'b0};

	// Keyword texts, left justified in 12 bytes.
	localparam logic [8*KEY_MAX_LEN-1:0] KEY_TEXT [KEY_COUNT] = '{
		{"PUMP_ON",             40'h0},
		{"PUMP_", "OFF",        32'h0},
		{"MIST_ON",             40'h0},
		{"MIST_", "OFF",        32'h0},
		{"AUTO_", "ENABLE",      8'h0},
		{"AUTO_", "DISABLE"          },
		{"SET_", "TIME",        32'h0}
	};

	localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{
		4'd7, 4'd8, 4'd7, 4'd8, 4'd11, 4'd12, 4'd8
	};

	// Byte idx of keyword k; positions past the text read as zero.
	function automatic logic [7:0] key_byte(input logic [2:0] k, input logic [3:0] idx);
		logic [8*KEY_MAX_LEN-1:0] t;
		t = KEY_TEXT[k] << (8 * idx);
		return t[8*KEY_MAX_LEN-1 -: 8];
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CHR_ZERO) && (b <= CHR_NINE);
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));
	endfunction

endpackage

// File: sv/ucl_time_parse.sv
// Next-state logic of the time setting field parser, one byte per call.
module ucl_time_parse (
	input  ucl_pkg::time_st_t cur,
	input  logic              en,
	input  logic              pos_is_eight,
	input  logic [7:0]        rx_byte,
	output ucl_pkg::time_st_t nxt
);
	import ucl_pkg::*;

	typedef enum logic [1:0] {
		SUB_NONE,
		SUB_START,
		SUB_SIGN,
		SUB_DIGITS
	} sub_t;

	sub_t       sub;
	logic [1:0] fld;
	logic [3:0] digit;
	logic [7:0] cur_val;
	logic [7:0] acc_val;

	// Split the phase into field number and position within the field.
	always_comb begin
		fld = 2'd0;
		sub = SUB_NONE;
		unique case (cur.phase)
			PH_F0_START:  begin fld = 2'd0; sub = SUB_START;  end
			PH_F0_SIGN:   begin fld = 2'd0; sub = SUB_SIGN;   end
			PH_F0_DIGITS: begin fld = 2'd0; sub = SUB_DIGITS; end
			PH_F1_START:  begin fld = 2'd1; sub = SUB_START;  end
			PH_F1_SIGN:   begin fld = 2'd1; sub = SUB_SIGN;   end
			PH_F1_DIGITS: begin fld = 2'd1; sub = SUB_DIGITS; end
			PH_F2_START:  begin fld = 2'd2; sub = SUB_START;  end
			PH_F2_SIGN:   begin fld = 2'd2; sub = SUB_SIGN;   end
			PH_F2_DIGITS: begin fld = 2'd2; sub = SUB_DIGITS; end
			default:      begin fld = 2'd0; sub = SUB_NONE;   end
		endcase
	end

	assign digit   = rx_byte[3:0];
	assign cur_val = cur.field[fld];
	// Decimal accumulate, kept modulo 256.
	assign acc_val = 8'({cur_val, 3'b000} + {cur_val, 1'b0} + {4'b0000, digit});

	// Advance the parse by one byte.
	always_comb begin
		nxt = cur;
		if (en) begin
			if (cur.phase == PH_LITERAL) begin
				if (pos_is_eight) begin
					nxt.phase = (rx_byte == CHR_COMMA) ? PH_F0_START : PH_FAIL;
				end
			end else begin
				case (sub)
					SUB_START: begin
						if (is_blank(rx_byte)) begin
							nxt = cur;
						end else if (rx_byte == CHR_PLUS || rx_byte == CHR_MINUS) begin
							nxt.negative   = (rx_byte == CHR_MINUS);
							nxt.field[fld] = 8'd0;
							nxt.phase      = phase_t'(4'(cur.phase + 4'd1));
						end else if (is_digit(rx_byte)) begin
							nxt.negative   = 1'b0;
							nxt.field[fld] = {4'b0000, digit};
							nxt.phase      = phase_t'(4'(cur.phase + 4'd2));
						end else begin
							nxt.phase = PH_FAIL;
						end
					end
					SUB_SIGN: begin
						if (is_digit(rx_byte)) begin
							nxt.field[fld] = {4'b0000, digit};
							nxt.phase      = phase_t'(4'(cur.phase + 4'd1));
						end else begin
							nxt.phase = PH_FAIL;
						end
					end
					SUB_DIGITS: begin
						if (is_digit(rx_byte)) begin
							nxt.field[fld] = acc_val;
						end else begin
							if (cur.negative) begin
								nxt.field[fld] = 8'(8'd0 - cur_val);
							end
							nxt.negative = 1'b0;
							if (fld == 2'd2) begin
								nxt.phase = PH_DONE;
							end else if (rx_byte == CHR_COMMA) begin
								nxt.phase = phase_t'(4'(cur.phase + 4'd1));
							end else begin
								nxt.phase = PH_FAIL;
							end
						end
					end
					default: begin
						nxt = cur;
					end
				endcase
			end
		end
	end

endmodule

// File: sv/uart_command_line_parser.sv
// Top level of the UART command line parser: keyword match, counters and result register.
//
//   Channel  Direction  Handshake            Payload
//   in       sink       in_valid/in_ready    rx_byte
//   out      source     out_valid/out_ready  status, command, hour, minute, second,
//                                            error_total
//
// Each received byte is judged in the cycle it is accepted; a result beat, when the
// byte causes one, appears on the outputs in the next cycle.
// One byte is taken every cycle while in_ready is high; the single result register is the only stage.
// in_ready falls only while a result is held and out_ready is low.
// Reset clears the line, the keyword match, the time parse and the error count.
module uart_command_line_parser #(
	parameter int LINE_BYTES = ucl_pkg::LINE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [2:0]  command,
	output logic [7:0]  hour,
	output logic [7:0]  minute,
	output logic [7:0]  second,
	output logic [31:0] error_total
);
	import ucl_pkg::*;

	localparam int LEN_W = $clog2(LINE_BYTES);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_BYTES - 1);

	// Line state
	logic [LEN_W-1:0]     len_q;
	logic [KEY_COUNT-1:0] alive_q;
	logic                 ended_q;
	time_st_t             time_q;
	logic [31:0]          err_q;

	// Result register
	logic        out_valid_q;
	status_t     status_q;
	cmd_t        command_q;
	logic [7:0]  hour_q;
	logic [7:0]  minute_q;
	logic [7:0]  second_q;
	logic [31:0] error_total_q;

	logic                 in_fire;
	logic                 overflow;
	logic                 active;
	logic                 newline;
	logic [KEY_COUNT-1:0] alive_nxt;
	time_st_t             time_nxt;
	logic [2:0]           first_key;
	logic                 any_key;
	logic [31:0]          err_inc;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign overflow = (len_q >= LEN_LIMIT);
	assign active   = !ended_q;
	assign newline  = (rx_byte == CHR_LF);
	assign err_inc  = err_q + 32'd1;

	// Drop each keyword whose text differs from the byte at this position.
	always_comb begin
		alive_nxt = alive_q;
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (active && (len_q < LEN_W'(KEY_LEN[k]))
					&& (rx_byte != key_byte(3'(k), len_q[3:0]))) begin
				alive_nxt[k] = 1'b0;
			end
		end
	end

	// First keyword still alive, in test order.
	always_comb begin
		first_key = 3'd0;
		any_key   = 1'b0;
		for (int k = KEY_COUNT - 1; k >= 0; k--) begin
			if (alive_nxt[k]) begin
				first_key = 3'(k);
				any_key   = 1'b1;
			end
		end
	end

	ucl_time_parse u_time_parse (
		.cur          (time_q),
		.en           (active),
		.pos_is_eight (len_q == LEN_W'(8)),
		.rx_byte      (rx_byte),
		.nxt          (time_nxt)
	);

	// Line state update on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			alive_q <= '1;
			ended_q <= 1'b0;
			time_q  <= TIME_CLEAR;
			err_q   <= '0;
		end else if (in_fire) begin
			if (overflow || newline) begin
				len_q   <= '0;
				alive_q <= '1;
				ended_q <= 1'b0;
				time_q  <= TIME_CLEAR;
			end else begin
				len_q   <= LEN_W'(len_q + 1'b1);
				alive_q <= alive_nxt;
				ended_q <= ended_q || (rx_byte == CHR_NUL);
				time_q  <= time_nxt;
			end
			if (overflow) begin
				err_q <= err_inc;
			end else if (newline && !(any_key && first_key != CMD_CLOCK_SET)
					&& !(any_key && time_nxt.phase == PH_DONE)) begin
				err_q <= err_inc;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= overflow || newline;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded when a byte closes or overflows the line.
	always_ff @(posedge clk) begin
		if (in_fire && (overflow || newline)) begin
			status_q      <= ST_UNKNOWN;
			command_q     <= CMD_PUMP_START;
			hour_q        <= 8'd0;
			minute_q      <= 8'd0;
			second_q      <= 8'd0;
			error_total_q <= err_inc;
			if (overflow) begin
				status_q <= ST_OVERFLOW;
			end else if (any_key && first_key != CMD_CLOCK_SET) begin
				status_q      <= ST_OK;
				command_q     <= cmd_t'(first_key);
				error_total_q <= err_q;
			end else if (any_key && time_nxt.phase == PH_DONE) begin
				status_q      <= ST_OK;
				command_q     <= CMD_CLOCK_SET;
				hour_q        <= time_nxt.field[0];
				minute_q      <= time_nxt.field[1];
				second_q      <= time_nxt.field[2];
				error_total_q <= err_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign command     = command_q;
	assign hour        = hour_q;
	assign minute      = minute_q;
	assign second      = second_q;
	assign error_total = error_total_q;

	// An overflowing byte always raises the error count.
	a_overflow_counts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && overflow |=> err_q == 32'($past(err_q) + 32'd1))
		else $error("overflow did not raise the error count");

	// A byte that neither ends nor overflows the line gives no result beat.
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !overflow && !newline |=> !out_valid_q)
		else $error("result beat without a line end");

	// The line grows by one byte or restarts.
	a_length_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (len_q == '0) || (len_q == LEN_W'($past(len_q) + 1'b1)))
		else $error("line length stepped wrongly");

	// Only the time setting command carries time fields.
	a_time_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && command_q != CMD_CLOCK_SET |->
			hour_q == 8'd0 && minute_q == 8'd0 && second_q == 8'd0)
		else $error("time fields set outside the time setting command");

endmodule

// File: tb/tb_uart_command_line_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench of the UART command line parser: byte stream in, line verdicts out.
module tb_uart_command_line_parser;
	import ucl_pkg::*;

	localparam int LINE_BYTES  = 64;
	localparam int BYTE_TARGET = 1050;
	localparam int QUIET_TAIL  = 150;

	// One expected line verdict.
	typedef struct {
		status_t     status;
		cmd_t        command;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [31:0] errors;
	} line_result_t;

	// Scoreboard: tracks the parser state byte by byte and holds the verdicts still due.
	class line_scoreboard;
		string                key_str [KEY_COUNT];
		line_result_t         verdicts [$];
		int                   line_len;
		logic [KEY_COUNT-1:0] alive;
		bit                   text_ended;
		phase_t               phase;
		logic [7:0]           field [3];
		bit                   negative;
		logic [31:0]          err_count;
		int                   fail_count;

		function new();
			key_str = '{"PUMP_ON", $sformatf("PUMP_%s", "OFF"), "MIST_ON",
				$sformatf("MIST_%s", "OFF"), $sformatf("AUTO_%s", "ENABLE"),
				$sformatf("AUTO_%s", "DISABLE"), $sformatf("SET_%s", "TIME")};
			err_count  = '0;
			fail_count = 0;
			clear_line();
		endfunction

		function void clear_line();
			line_len   = 0;
			alive      = '1;
			text_ended = 1'b0;
			phase      = PH_LITERAL;
			field[0]   = '0;
			field[1]   = '0;
			field[2]   = '0;
			negative   = 1'b0;
		endfunction

		function bit blank_byte(logic [7:0] b);
			return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
		endfunction

		function bit digit_byte(logic [7:0] b);
			return (b >= CHR_ZERO) && (b <= CHR_NINE);
		endfunction

		function void push_verdict(status_t st, cmd_t cmd, logic [7:0] h, logic [7:0] m,
				logic [7:0] s);
			line_result_t r;
			r.status  = st;
			r.command = cmd;
			r.hour    = h;
			r.minute  = m;
			r.second  = s;
			r.errors  = err_count;
			verdicts.push_back(r);
		endfunction

		// Time setting parse: a comma after the prefix, then three signed decimal fields.
		function void step_time(int pos, logic [7:0] b);
			int f;
			int sub;
			if (phase == PH_LITERAL) begin
				if (pos == 8)
					phase = (b == CHR_COMMA) ? PH_F0_START : PH_FAIL;
				return;
			end
			if (phase < PH_F0_START || phase > PH_F2_DIGITS)
				return;
			f   = (int'(phase) - 1) / 3;
			sub = (int'(phase) - 1) % 3;
			if (sub == 0) begin
				if (blank_byte(b)) begin
					return;
				end else if (b == CHR_PLUS || b == CHR_MINUS) begin
					negative = (b == CHR_MINUS);
					field[f] = '0;
					phase    = phase_t'(phase + 1);
				end else if (digit_byte(b)) begin
					negative = 1'b0;
					field[f] = b - CHR_ZERO;
					phase    = phase_t'(phase + 2);
				end else begin
					phase = PH_FAIL;
				end
			end else if (sub == 1) begin
				if (digit_byte(b)) begin
					field[f] = b - CHR_ZERO;
					phase    = phase_t'(phase + 1);
				end else begin
					phase = PH_FAIL;
				end
			end else begin
				if (digit_byte(b)) begin
					field[f] = 8'(field[f] * 8'd10 + (b - CHR_ZERO));
					return;
				end
				if (negative)
					field[f] = 8'(8'd0 - field[f]);
				negative = 1'b0;
				if (f == 2)
					phase = PH_DONE;
				else
					phase = (b == CHR_COMMA) ? phase_t'(phase + 1) : PH_FAIL;
			end
		endfunction

		// Notes one accepted input beat and queues the verdict it causes, if any.
		function void note_byte(logic [7:0] b);
			int pos;
			int k;
			if (line_len >= LINE_BYTES - 1) begin
				clear_line();
				err_count = err_count + 1;
				// The command field reads as code zero on any verdict but a command.
				push_verdict(ST_OVERFLOW, CMD_PUMP_START, '0, '0, '0);
				return;
			end
			pos      = line_len;
			line_len = line_len + 1;
			if (!text_ended) begin
				for (k = 0; k < KEY_COUNT; k++)
					if (pos < key_str[k].len() && b != 8'(key_str[k][pos]))
						alive[k] = 1'b0;
				step_time(pos, b);
				if (b == CHR_NUL)
					text_ended = 1'b1;
			end
			if (b != CHR_LF)
				return;
			k = 0;
			while (k < KEY_COUNT && !alive[k])
				k++;
			if (k < int'(CMD_CLOCK_SET)) begin
				push_verdict(ST_OK, cmd_t'(k), '0, '0, '0);
			end else if (k == int'(CMD_CLOCK_SET) && phase == PH_DONE) begin
				push_verdict(ST_OK, CMD_CLOCK_SET, field[0], field[1], field[2]);
			end else begin
				err_count = err_count + 1;
				push_verdict(ST_UNKNOWN, CMD_PUMP_START, '0, '0, '0);
			end
			clear_line();
		endfunction

		function void compare_field(string name, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
				fail_count++;
			end
		endfunction

		// Checks one accepted result beat against the oldest verdict due.
		function void check_result(logic [1:0] st, logic [2:0] cmd, logic [7:0] h,
				logic [7:0] m, logic [7:0] s, logic [31:0] errs);
			line_result_t r;
			if (verdicts.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual status %0d",
					$time, st);
				fail_count++;
				return;
			end
			r = verdicts.pop_front();
			compare_field("status", r.status, st);
			compare_field("command", r.command, cmd);
			compare_field("hour", r.hour, h);
			compare_field("minute", r.minute, m);
			compare_field("second", r.second, s);
			compare_field("error_total", r.errors, errs);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [2:0]  command;
	logic [7:0]  hour;
	logic [7:0]  minute;
	logic [7:0]  second;
	logic [31:0] error_total;

	line_scoreboard sb = new();
	logic [7:0]     line_buf [$];
	bit             idle_on;
	bit             drained;
	int             sent_count;
	int             stall_left;

	uart_command_line_parser #(
		.LINE_BYTES(LINE_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.command(command),
		.hour(hour),
		.minute(minute),
		.second(second),
		.error_total(error_total)
	);

	// Free-running clock.
	always #6 clk = ~clk;

	// Monitor: both channels are sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(status, command, hour, minute, second, error_total);
			if (in_valid && in_ready)
				sb.note_byte(rx_byte);
		end
	end

	// Receiver: stalls in random bursts while idling is allowed.
	always @(negedge clk) begin
		if (!idle_on) begin
			out_ready <= 1'b1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 18);
		end
	end

	// Sends one input beat, with a random gap in front of it while idling is allowed.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		sent_count++;
	endtask

	task automatic send_line();
		foreach (line_buf[i])
			send_byte(line_buf[i]);
		line_buf.delete();
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(8'(s[i]));
	endtask

	task automatic push_digits(input int n);
		repeat (n) line_buf.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
	endtask

	// A printable byte that is never a newline.
	function automatic logic [7:0] printable_byte();
		return 8'($urandom_range(33, 126));
	endfunction

	// Builds a time setting line with random blanks, signs and digit counts.
	task automatic push_clock_line();
		int sel;
		push_text({sb.key_str[CMD_CLOCK_SET], ","});
		for (int f = 0; f < 3; f++) begin
			repeat ($urandom_range(0, 2)) begin
				sel = $urandom_range(0, 4);
				line_buf.push_back(sel == 0 ? CHR_SPACE : 8'(sel == 1 ? 9 : sel + 9));
			end
			sel = $urandom_range(0, 3);
			if (sel == 0)
				line_buf.push_back(CHR_PLUS);
			else if (sel == 1)
				line_buf.push_back(CHR_MINUS);
			push_digits($urandom_range(1, 4));
			if (f < 2)
				line_buf.push_back(CHR_COMMA);
		end
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 4)) line_buf.push_back(printable_byte());
	endtask

	// Builds one random line; most are well formed, the rest damaged or noise.
	task automatic build_random_line();
		int kind;
		int pos;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			push_text(sb.key_str[$urandom_range(0, KEY_COUNT - 1)]);
			repeat ($urandom_range(0, 5)) line_buf.push_back(printable_byte());
			line_buf.push_back(CHR_LF);
		end else if (kind < 70) begin
			push_clock_line();
			line_buf.push_back(CHR_LF);
		end else if (kind < 80) begin
			if ($urandom_range(0, 1))
				push_clock_line();
			else
				push_text(sb.key_str[$urandom_range(0, KEY_COUNT - 1)]);
			pos = $urandom_range(0, line_buf.size() - 1);
			if ($urandom_range(0, 2) == 0)
				line_buf[pos] = CHR_NUL;
			else
				line_buf[pos] = 8'($urandom_range(0, 255));
			line_buf.push_back(CHR_LF);
		end else if (kind < 88) begin
			repeat ($urandom_range(0, 3)) line_buf.push_back(printable_byte());
			line_buf.push_back(CHR_LF);
		end else if (kind < 94) begin
			repeat ($urandom_range(55, 70)) line_buf.push_back(printable_byte());
			line_buf.push_back(CHR_LF);
		end else begin
			repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Run limit, far above the slowest correct run.
	initial begin
		#8_000_000;
		$display("tb_uart_command_line_parser: FAIL");
		$finish;
	end

	// Stimulus and end of run.
	initial begin
		string clock_key;
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		rx_byte    = '0;
		out_ready  = 1'b0;
		idle_on    = 1'b1;
		drained    = 1'b0;
		sent_count = 0;
		stall_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed lines: every command, the test order, signs, blanks and wrap of fields.
		for (int k = 0; k < int'(CMD_CLOCK_SET); k++)
			push_text({sb.key_str[k], "\n"});
		clock_key = sb.key_str[CMD_CLOCK_SET];
		push_text({clock_key, ",-1,+300, \t\r\v\f99999x\n"});
		push_text({clock_key, ",0,0,0\n"});
		send_line();
		// An empty line, a short time line and a missing comma are all unknown.
		push_text({"\n", clock_key, ",1,2\n", clock_key, ";1,2,3\n", clock_key, ",+,1,2\n"});
		// A newline counts as a blank inside a field, so it ends the line unfinished.
		push_text({clock_key, ",\n"});
		send_line();
		// The text ends at a NUL byte: once before the keyword is complete, once after.
		push_text("PUMP");
		line_buf.push_back(CHR_NUL);
		push_text("_ON\nPUMP_ON");
		line_buf.push_back(CHR_NUL);
		push_text("zz\n");
		send_line();
		// A line of the longest length, then one that overflows.
		repeat (LINE_BYTES - 2) line_buf.push_back(8'hFF);
		line_buf.push_back(CHR_LF);
		repeat (LINE_BYTES + 4) line_buf.push_back(8'h00);
		line_buf.push_back(CHR_LF);
		send_line();

		// Random lines; the sender waits once for the scoreboard to drain.
		while (sent_count < BYTE_TARGET) begin
			if (sent_count >= BYTE_TARGET - QUIET_TAIL)
				idle_on = 1'b0;
			build_random_line();
			send_line();
			if (!drained && sent_count >= BYTE_TARGET / 2) begin
				drained = 1'b1;
				@(negedge clk);
				in_valid <= 1'b0;
				while (sb.verdicts.size() != 0) @(negedge clk);
			end
		end

		// Drain and report.
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.verdicts.size() != 0) @(negedge clk);
		repeat (16) @(negedge clk);
		if (sb.verdicts.size() != 0) begin
			$display("%0t: %0d verdicts never arrived, expected 0, actual %0d", $time,
				sb.verdicts.size(), sb.verdicts.size());
			sb.fail_count++;
		end
		if (sb.fail_count == 0)
			$display("tb_uart_command_line_parser: PASS");
		else
			$display("tb_uart_command_line_parser: FAIL");
		$finish;
	end
endmodule
